// ===== rtl/slt_pkg.sv =====
// Shared types, constants and table-building functions of the sine LFO tremolo block.
`default_nettype none

package slt_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PHASE_STEP   = 2'd0,
		REG_DEPTH        = 2'd1,
		REG_SMOOTH_COEFF = 2'd2
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	// Register widths and reset values.
	localparam int STEP_W  = 24;
	localparam int DEPTH_W = 16;
	localparam int COEFF_W = 16;
	localparam int GAIN_W  = 16;
	localparam int PHASE_W = 32;
	localparam int SINE_W  = 16;

	localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd447392;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd0;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd65365;
	localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'd32768;

	// Depth below this passes samples through; depth above full is clamped.
	localparam logic [DEPTH_W-1:0] DEPTH_MIN  = 16'd33;
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = 16'd32768;

	// 0.35 in Q0.16.
	localparam int SCALE_035_Q16 = 22938;

	// Shared multiplier operand widths (signed).
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam longint Q30_ONE = longint'(1) <<< 30;

	// Q30 product, rounded half away from zero.
	function automatic longint mul_q30(input longint a, input longint b);
		longint ma;
		longint mb;
		longint m;
		logic   neg;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		m   = (ma * mb + (longint'(1) <<< 29)) >>> 30;
		return neg ? -m : m;
	endfunction

	// sin(pi/2 * x) for x in Q30 over [0, 1], result in Q30.
	function automatic longint quarter_sine(input longint x);
		longint x2;
		longint p;
		x2 = mul_q30(x, x);
		p  = 172272;
		p  = -5026995 + mul_q30(p, x2);
		p  = 85569306 + mul_q30(p, x2);
		p  = -693598670 + mul_q30(p, x2);
		p  = 1686629713 + mul_q30(p, x2);
		return mul_q30(p, x);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sine_lfo_tremolo_core.sv =====
// Sine LFO tremolo: phase accumulator, sine ROM, gain smoother and sample scaling.
//
// Input items arrive on s_tvalid/s_tready/s_tdata (left sample in the low
// bits, right sample above it); results leave on m_tvalid/m_tready/m_tdata
// with the same layout. For mono use drive and read the left field only.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data, which
// is always ready; index 0 is the phase step, 1 the depth, 2 the smoothing
// coefficient, and other indexes are ignored.
// A single 33 x 18 bit multiplier is stepped by a sequencer through the ROM
// index, the gain reduction, the two smoother products and both samples.
// With modulation active an accepted item goes through the index, ROM,
// reduction, smoother, gain and sample steps to the output state, and the
// next item is accepted only once the result register is loaded. With depth
// below the pass-through threshold the item goes straight to the output state.
// The ROM is read through a registered port.
// The result register holds a finished item while the receiver stalls; a new
// item is taken in meanwhile, and the sequencer waits only when its next
// result is ready and the register is still full.
// Reset clears the phase, sets unity gain and loads the register defaults.
`default_nettype none

module sine_lfo_tremolo_core #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int SAMPLE_WIDTH     = 24,
	localparam int TDATA_W         = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input items; fields from bit 0: left_in, right_in.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [TDATA_W-1:0]               s_tdata,
	// Result items; fields from bit 0: left_out, right_out.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [TDATA_W-1:0]                    m_tdata,
	// Register writes.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [slt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [slt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import slt_pkg::*;

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int SW    = SAMPLE_WIDTH;

	typedef logic signed [SINE_W-1:0] rom_arr_t [SINE_TABLE_DEPTH];

	// One ROM entry: quarter-wave polynomial, mirrored and negated by quadrant.
	function automatic logic signed [SINE_W-1:0] rom_entry(input int k);
		longint t;
		longint quad;
		longint rem;
		longint x;
		longint s;
		t    = longint'(k) * 4;
		quad = t / SINE_TABLE_DEPTH;
		rem  = t - quad * SINE_TABLE_DEPTH;
		x    = (rem <<< 30) / SINE_TABLE_DEPTH;
		if (quad[0]) begin
			x = Q30_ONE - x;
		end
		s = quarter_sine(x);
		if (s < 0) begin
			s = 0;
		end
		s = (s + 16384) >>> 15;
		if (s > 32767) begin
			s = 32767;
		end
		if (quad[1]) begin
			s = -s;
		end
		return SINE_W'(s);
	endfunction

	function automatic rom_arr_t build_rom();
		rom_arr_t r;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			r[k] = rom_entry(k);
		end
		return r;
	endfunction

	localparam rom_arr_t SINE_ROM = build_rom();

	typedef enum logic [3:0] {
		S_IDLE,
		S_IDX,
		S_ROM,
		S_RED1,
		S_RED2,
		S_G1,
		S_G2,
		S_GAIN,
		S_L,
		S_R,
		S_RSV,
		S_OUT
	} state_t;

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic [DEPTH_W-1:0]         depth_q;
	logic [COEFF_W-1:0]         coeff_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [GAIN_W-1:0]          gain_q;
	logic [DEPTH_W-1:0]         d_q;
	logic signed [SW-1:0]       l_q;
	logic signed [SW-1:0]       r_q;
	logic signed [SINE_W-1:0]   rom_q;
	logic [GAIN_W-1:0]          target_q;
	logic [32:0]                acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SW-1:0]       res_l_q;
	logic signed [SW-1:0]       res_r_q;
	logic                       out_valid_q;
	logic [TDATA_W-1:0]         out_data_q;

	logic [DEPTH_W-1:0]         d_clamp;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic [IDX_W-1:0]           rom_idx;
	logic signed [PROD_W-1:0]   rnd_sum;
	logic [PROD_W-1:0]          red_sum;
	logic [GAIN_W-1:0]          red;
	logic [32:0]                gain_sum;
	logic                       in_acc;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign in_acc    = s_tvalid && s_tready;

	// Depth clamped to full scale.
	assign d_clamp = (depth_q > DEPTH_FULL) ? DEPTH_FULL : depth_q;

	// Shared multiplier operands, chosen by the sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_IDX: begin
				mul_a = $signed({1'b0, phase_q});
				mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
			end
			S_RED1: begin
				mul_a = $signed(MUL_A_W'({1'b0, d_q}));
				mul_b = MUL_B_W'(32768) - MUL_B_W'(rom_q);
			end
			S_RED2: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(SCALE_035_Q16);
			end
			S_G1: begin
				mul_a = $signed(MUL_A_W'({1'b0, gain_q}));
				mul_b = $signed(MUL_B_W'({1'b0, coeff_q}));
			end
			S_G2: begin
				mul_a = $signed(MUL_A_W'({1'b0, target_q}));
				mul_b = MUL_B_W'(65536) - $signed(MUL_B_W'({1'b0, coeff_q}));
			end
			S_L: begin
				mul_a = MUL_A_W'(l_q);
				mul_b = $signed(MUL_B_W'({1'b0, gain_q}));
			end
			S_R: begin
				mul_a = MUL_A_W'(r_q);
				mul_b = $signed(MUL_B_W'({1'b0, gain_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Result decoding from the product register.
	assign rom_idx  = prod_q[32 +: IDX_W];
	assign red_sum  = prod_q + PROD_W'(64'd1073741824);
	assign red      = red_sum[31 +: GAIN_W];
	assign rnd_sum  = prod_q + PROD_W'(16384);
	assign gain_sum = acc_q + prod_q[32:0] + 33'd32768;

	// ROM read port, registered.
	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[rom_idx];
	end

	// Multiplier output register; operands are sign-extended to the full product width.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Sequencer, state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_RESET;
			depth_q     <= DEPTH_RESET;
			coeff_q     <= COEFF_RESET;
			phase_q     <= '0;
			gain_q      <= GAIN_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PHASE_STEP:   step_q  <= cfg_data[STEP_W-1:0];
					REG_DEPTH:        depth_q <= cfg_data[DEPTH_W-1:0];
					REG_SMOOTH_COEFF: coeff_q <= cfg_data[COEFF_W-1:0];
					default: ;
				endcase
			end

			// The result register empties when taken, unless it is reloaded below.
			if (out_valid_q && m_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						l_q <= s_tdata[SW-1:0];
						r_q <= s_tdata[2*SW-1:SW];
						d_q <= d_clamp;
						if (d_clamp < DEPTH_MIN) begin
							res_l_q <= s_tdata[SW-1:0];
							res_r_q <= s_tdata[2*SW-1:SW];
							state_q <= S_OUT;
						end else begin
							state_q <= S_IDX;
						end
					end
				end
				S_IDX:  state_q <= S_ROM;
				S_ROM:  state_q <= S_RED1;
				S_RED1: state_q <= S_RED2;
				S_RED2: state_q <= S_G1;
				S_G1: begin
					target_q <= GAIN_ONE - red;
					state_q  <= S_G2;
				end
				S_G2: begin
					acc_q   <= prod_q[32:0];
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					gain_q  <= gain_sum[31:16];
					state_q <= S_L;
				end
				S_L: state_q <= S_R;
				S_R: begin
					res_l_q <= rnd_sum[15 +: SW];
					state_q <= S_RSV;
				end
				S_RSV: begin
					res_r_q <= rnd_sum[15 +: SW];
					phase_q <= phase_q + PHASE_W'(step_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Load the result register once it is free or being emptied.
					if (!out_valid_q || m_tready) begin
						out_data_q  <= TDATA_W'({res_r_q, res_l_q});
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The phase moves only at the end of a modulated item.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_RSV && arst_n) |=> $stable(phase_q))
		else $error("phase changed outside its update step");

	// The smoothed gain never exceeds unity.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= GAIN_ONE)
		else $error("smoothed gain above unity");

	// An accepted item always starts work in the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_IDX || state_q == S_OUT))
		else $error("accepted item did not start");
`endif

endmodule

`default_nettype wire
